// File: rtl/differential_odometry_integrator_unit_assert.svh
// Assertion macros shared by the odometry integrator RTL.
// Included inside module bodies; depends on nothing else.
`ifndef DIFFERENTIAL_ODOMETRY_INTEGRATOR_UNIT_ASSERT_SVH
`define DIFFERENTIAL_ODOMETRY_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DOI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry integrator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DOI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry integrator assertion failed");

`endif

// File: rtl/doi_pkg.sv
// Shared types and constants of the odometry integrator.
// Used by every module of the block; depends on nothing.
package doi_pkg;

    localparam int POS_W   = 32;
    localparam int HEAD_W  = 16;
    localparam int ACC_W   = 40;
    localparam int SUM_W   = 35;
    localparam int ANGLE_W = 15;
    localparam int SCALE_W = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

    localparam logic [HEAD_W-1:0] FULL_TURN          = 16'd36000;
    localparam logic [HEAD_W-1:0] QUARTER_TURN       = 16'd9000;
    localparam logic [HEAD_W-1:0] HALF_TURN          = 16'd18000;
    localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = 16'd27000;

    // CORDIC works on Q30 values; one hundredth of a degree is 4096 angle units.
    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_W     = 32;
    localparam int ANGLE_SHIFT  = 12;
    localparam int Z_W          = 28;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        28'sd18432000, 28'sd10881045, 28'sd5749245, 28'sd2918407, 28'sd1464867,
        28'sd733147,   28'sd366663,   28'sd183343,  28'sd91673,   28'sd45837,
        28'sd22918,    28'sd11459,    28'sd5730,    28'sd2865,    28'sd1432,
        28'sd716,      28'sd358,      28'sd179,     28'sd90,      28'sd45
    };

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [POS_W-1:0] left_position;
        logic signed [POS_W-1:0] right_position;
        logic [HEAD_W-1:0]       heading_sample;
    } doi_in_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] pos_x;
        logic signed [ACC_W-1:0] pos_y;
        logic [HEAD_W-1:0]       heading_now;
        logic signed [ACC_W-1:0] total_distance;
    } doi_out_t;

    // One classified step, passed from the front part to the back part.
    typedef struct packed {
        logic signed [SUM_W-1:0]   wheel_sum;
        logic signed [ANGLE_W-1:0] trig_angle;
        logic                      trig_flip;
        logic [HEAD_W-1:0]         heading_new;
    } doi_job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CORDIC,
        BK_ROUND,
        BK_MUL,
        BK_COMBINE,
        BK_ACCUM
    } doi_back_state_t;

endpackage

// File: rtl/doi_front.sv
// Front part of the odometry integrator: accepts items and classifies them.
// Depends on doi_pkg.
module doi_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  doi_pkg::doi_in_t  in_item,
    output logic              push_valid,
    input  logic              push_ready,
    output doi_pkg::doi_job_t push_job
);
    import doi_pkg::*;

    logic signed [POS_W-1:0] last_left_reg;
    logic signed [POS_W-1:0] last_right_reg;
    logic [HEAD_W-1:0]       heading_reg;
    logic                    accept;
    logic [HEAD_W-1:0]       heading_mod;
    logic signed [HEAD_W:0]  fold_angle;
    logic                    fold_flip;

    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign accept     = in_valid && push_ready;

    // The trig uses the heading stored by the previous item, folded into +-90 degrees.
    always_comb
    begin
        heading_mod = (heading_reg >= FULL_TURN) ? heading_reg - FULL_TURN : heading_reg;
        fold_flip   = 1'b0;
        if (heading_mod < QUARTER_TURN)
        begin
            fold_angle = $signed({1'b0, heading_mod});
        end
        else if (heading_mod < THREE_QUARTER_TURN)
        begin
            fold_angle = $signed({1'b0, heading_mod}) - $signed({1'b0, HALF_TURN});
            fold_flip  = 1'b1;
        end
        else
        begin
            fold_angle = $signed({1'b0, heading_mod}) - $signed({1'b0, FULL_TURN});
        end
    end

    always_comb
    begin
        push_job.wheel_sum   = (SUM_W'(in_item.left_position) - SUM_W'(last_left_reg))
                             + (SUM_W'(in_item.right_position) - SUM_W'(last_right_reg));
        push_job.trig_angle  = fold_angle[ANGLE_W-1:0];
        push_job.trig_flip   = fold_flip;
        push_job.heading_new = in_item.heading_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
            heading_reg    <= '0;
        end
        else if (accept)
        begin
            last_left_reg  <= in_item.left_position;
            last_right_reg <= in_item.right_position;
            heading_reg    <= in_item.heading_sample;
        end
    end

endmodule

// File: rtl/doi_queue.sv
// Short job queue between the front and back parts of the odometry integrator.
// Depends on doi_pkg and the shared assertion macros.
module doi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  doi_pkg::doi_job_t push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output doi_pkg::doi_job_t pop_job
);
    import doi_pkg::*;
    `include "differential_odometry_integrator_unit_assert.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    doi_job_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `DOI_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `DOI_ASSERT_NEXT(a_count_grows, clk, rst_n, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1)

endmodule

// File: rtl/doi_back.sv
// Back part of the odometry integrator: CORDIC sine/cosine, distance scaling,
// saturating accumulation and the output register. Depends on doi_pkg and the
// shared assertion macros.
module doi_back #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [doi_pkg::SCALE_W-1:0]  distance_scale,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  doi_pkg::doi_job_t            pop_job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output doi_pkg::doi_out_t            out_item
);
    import doi_pkg::*;
    `include "differential_odometry_integrator_unit_assert.svh"

    localparam int TW      = TRIG_FRAC_BITS + 1;
    localparam int RND_SH  = CORDIC_FRAC - TRIG_FRAC_BITS;
    localparam int HALF_W  = ACC_W / 2;
    localparam int PP_W    = HALF_W + TW;
    localparam int PROD_W  = ACC_W + TW;
    localparam int INC_W   = ACC_W + 2;
    localparam int MAG_W   = SUM_W - 1;
    localparam int LO_W    = SCALE_W;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int DPROD_W = MAG_W + SCALE_W;
    localparam int ITER_W  = $clog2(CORDIC_STEPS);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
    // Steps of the distance path, overlapped with the first CORDIC iterations.
    localparam logic [ITER_W-1:0] STEP_ABS  = ITER_W'(0);
    localparam logic [ITER_W-1:0] STEP_MUL  = ITER_W'(1);
    localparam logic [ITER_W-1:0] STEP_SAT  = ITER_W'(2);
    localparam logic [ITER_W-1:0] STEP_ACC  = ITER_W'(3);

    localparam logic [TW-1:0]       TRIG_ONE  = {1'b1, {TRIG_FRAC_BITS{1'b0}}};
    localparam logic [CORDIC_W:0]   RND_HALF  = {{CORDIC_W{1'b0}}, 1'b1} << (RND_SH - 1);
    localparam logic [PROD_W:0]     PROD_HALF = {{PROD_W{1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);
    localparam logic [ACC_W-1:0]    STEP_MAX  = {ACC_W{1'b1}};

    // Rounds a Q30 CORDIC output half away from zero and clamps the magnitude to 1.0.
    function automatic logic [TW-1:0] trig_mag(input logic signed [CORDIC_W-1:0] v);
        logic [CORDIC_W-1:0] m;
        logic [CORDIC_W:0]   r;
        m = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
        r = ({1'b0, m} + RND_HALF) >> RND_SH;
        if (r > (CORDIC_W + 1)'(TRIG_ONE))
        begin
            trig_mag = TRIG_ONE;
        end
        else
        begin
            trig_mag = r[TW-1:0];
        end
    endfunction

    // Joins the two partial products, rounds half away from zero and applies the sign.
    function automatic logic signed [INC_W-1:0] scale_round(
        input logic [PP_W-1:0] pp0,
        input logic [PP_W-1:0] pp1,
        input logic            neg
    );
        logic [PROD_W:0] p;
        logic [PROD_W:0] q;
        p = (PROD_W + 1)'(pp0) + ((PROD_W + 1)'(pp1) << HALF_W) + PROD_HALF;
        q = p >> TRIG_FRAC_BITS;
        scale_round = neg ? -$signed({1'b0, q[ACC_W:0]}) : $signed({1'b0, q[ACC_W:0]});
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [INC_W-1:0] b
    );
        logic signed [INC_W:0] s;
        s = (INC_W + 1)'(a) + (INC_W + 1)'(b);
        if ((&s[INC_W:ACC_W-1]) || !(|s[INC_W:ACC_W-1]))
        begin
            sat_add = s[ACC_W-1:0];
        end
        else if (s[INC_W])
        begin
            sat_add = {1'b1, {(ACC_W - 1){1'b0}}};
        end
        else
        begin
            sat_add = {1'b0, {(ACC_W - 1){1'b1}}};
        end
    endfunction

    doi_back_state_t state_reg;
    doi_back_state_t state_next;
    logic            out_load;

    logic [ITER_W-1:0]          iter_reg;
    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic signed [CORDIC_W-1:0] x_shift;
    logic signed [CORDIC_W-1:0] y_shift;
    logic                       flip_reg;
    logic [HEAD_W-1:0]          heading_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic                    sum_neg_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [2*LO_W-1:0]       pp_lo_reg;
    logic [HI_W+LO_W-1:0]    pp_hi_reg;
    logic [DPROD_W-1:0]      dprod;
    logic [ACC_W-1:0]        md_reg;

    logic [TW-1:0] cos_mag_reg;
    logic [TW-1:0] sin_mag_reg;
    logic          cos_neg_reg;
    logic          sin_neg_reg;
    logic [PP_W-1:0] ppx0_reg;
    logic [PP_W-1:0] ppx1_reg;
    logic [PP_W-1:0] ppy0_reg;
    logic [PP_W-1:0] ppy1_reg;
    logic signed [INC_W-1:0] incx_reg;
    logic signed [INC_W-1:0] incy_reg;
    logic signed [INC_W-1:0] dinc;

    logic signed [ACC_W-1:0] acc_x_reg;
    logic signed [ACC_W-1:0] acc_y_reg;
    logic signed [ACC_W-1:0] acc_d_reg;
    logic signed [ACC_W-1:0] acc_x_next;
    logic signed [ACC_W-1:0] acc_y_next;

    logic     out_valid_reg;
    doi_out_t out_item_reg;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign x_shift = x_reg >>> iter_reg;
    assign y_shift = y_reg >>> iter_reg;

    assign dprod = DPROD_W'(pp_lo_reg) + (DPROD_W'(pp_hi_reg) << LO_W);
    assign dinc  = sum_neg_reg ? -$signed({2'b00, md_reg}) : $signed({2'b00, md_reg});

    assign acc_x_next = sat_add(acc_x_reg, incx_reg);
    assign acc_y_next = sat_add(acc_y_reg, incy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    state_next = BK_CORDIC;
                end
            end
            BK_CORDIC:
            begin
                if (iter_reg == ITER_LAST)
                begin
                    state_next = BK_ROUND;
                end
            end
            BK_ROUND:   state_next = BK_MUL;
            BK_MUL:     state_next = BK_COMBINE;
            BK_COMBINE: state_next = BK_ACCUM;
            BK_ACCUM:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:    state_next = BK_IDLE;
        endcase
    end

    // Control counter, accumulators and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg      <= '0;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_d_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == BK_CORDIC)
            begin
                iter_reg <= iter_reg + 1'b1;
            end
            else
            begin
                iter_reg <= '0;
            end
            if (state_reg == BK_CORDIC && iter_reg == STEP_ACC)
            begin
                acc_d_reg <= sat_add(acc_d_reg, dinc);
            end
            if (out_load)
            begin
                acc_x_reg     <= acc_x_next;
                acc_y_reg     <= acc_y_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    x_reg       <= CORDIC_GAIN;
                    y_reg       <= '0;
                    z_reg       <= Z_W'(pop_job.trig_angle) <<< ANGLE_SHIFT;
                    flip_reg    <= pop_job.trig_flip;
                    heading_reg <= pop_job.heading_new;
                    sum_reg     <= pop_job.wheel_sum;
                end
            end
            BK_CORDIC:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_reg <= x_reg - y_shift;
                    y_reg <= y_reg + x_shift;
                    z_reg <= z_reg - ATAN_TAB[iter_reg];
                end
                else
                begin
                    x_reg <= x_reg + y_shift;
                    y_reg <= y_reg - x_shift;
                    z_reg <= z_reg + ATAN_TAB[iter_reg];
                end
                // The step distance is worked out while the rotation runs.
                if (iter_reg == STEP_ABS)
                begin
                    sum_neg_reg <= sum_reg[SUM_W-1];
                    mag_reg     <= sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
                end
                if (iter_reg == STEP_MUL)
                begin
                    pp_lo_reg <= (2*LO_W)'(mag_reg[LO_W-1:0]) * (2*LO_W)'(distance_scale);
                    pp_hi_reg <= (HI_W+LO_W)'(mag_reg[MAG_W-1:LO_W])
                               * (HI_W+LO_W)'(distance_scale);
                end
                if (iter_reg == STEP_SAT)
                begin
                    md_reg <= (|dprod[DPROD_W-1:ACC_W+1]) ? STEP_MAX : dprod[ACC_W:1];
                end
            end
            BK_ROUND:
            begin
                cos_mag_reg <= trig_mag(x_reg);
                sin_mag_reg <= trig_mag(y_reg);
                cos_neg_reg <= x_reg[CORDIC_W-1] ^ flip_reg;
                sin_neg_reg <= y_reg[CORDIC_W-1] ^ flip_reg;
            end
            BK_MUL:
            begin
                ppx0_reg <= PP_W'(md_reg[HALF_W-1:0]) * PP_W'(cos_mag_reg);
                ppx1_reg <= PP_W'(md_reg[ACC_W-1:HALF_W]) * PP_W'(cos_mag_reg);
                ppy0_reg <= PP_W'(md_reg[HALF_W-1:0]) * PP_W'(sin_mag_reg);
                ppy1_reg <= PP_W'(md_reg[ACC_W-1:HALF_W]) * PP_W'(sin_mag_reg);
            end
            BK_COMBINE:
            begin
                incx_reg <= scale_round(ppx0_reg, ppx1_reg, sum_neg_reg ^ cos_neg_reg);
                incy_reg <= scale_round(ppy0_reg, ppy1_reg, sum_neg_reg ^ sin_neg_reg);
            end
            BK_ACCUM:
            begin
                if (out_load)
                begin
                    out_item_reg.pos_x          <= acc_x_next;
                    out_item_reg.pos_y          <= acc_y_next;
                    out_item_reg.heading_now    <= heading_reg;
                    out_item_reg.total_distance <= acc_d_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    `DOI_ASSERT_NEXT(a_cordic_exit, clk, rst_n, state_reg == BK_CORDIC && iter_reg == ITER_LAST, state_reg == BK_ROUND)
    `DOI_ASSERT_IMP(a_iter_range, clk, rst_n, state_reg == BK_CORDIC, iter_reg <= ITER_LAST)

endmodule

// File: rtl/differential_odometry_integrator_unit.sv
// Top level of the differential-drive odometry integrator.
// Depends on doi_pkg, doi_front, doi_queue and doi_back.
//
// Usage: each input item carries absolute left and right wheel encoder counts
// and a heading sample in hundredths of a degree. The block returns one result
// item per input item with the saturating x, y and distance accumulators and
// the heading it has just stored. Both channels use valid and ready; the one
// configuration register, distance_scale (Q31.1), is written with cfg_we and
// cfg_wdata; the user must write it only while the block is idle, which the
// block itself does not enforce. The back part takes one item at a time and
// finishes it before it takes the next: a load state, 20 iterations of the
// shared CORDIC rotator, then the round, multiply, combine and accumulate
// states. The step distance is computed during the first CORDIC iterations.
// A two-item queue sits between the front part and the back part, so the input
// keeps accepting while the back part is busy until the queue fills.
// Reset clears the accumulators, the stored encoder counts and the heading,
// and sets distance_scale to 32768.0. When the receiver stalls, the result stays
// in the output register, the back part holds its next result, and the queue
// then fills and lowers in_ready.
module differential_odometry_integrator_unit #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  doi_pkg::doi_in_t             in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output doi_pkg::doi_out_t            out_item,
    input  logic                         cfg_we,
    input  logic [doi_pkg::SCALE_W-1:0]  cfg_wdata
);
    import doi_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic               push_valid;
    logic               push_ready;
    doi_job_t           push_job;
    logic               pop_valid;
    logic               pop_ready;
    doi_job_t           pop_job;

    // The user must write the scale register only while no item is in flight, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    // Front part: wheel deltas and heading fold, one item per cycle while the queue has room.
    doi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    doi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Back part: CORDIC, scaling and saturating accumulation.
    doi_back #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .distance_scale (scale_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_job        (pop_job),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item)
    );

endmodule
